FILE: rtl/vzr_pkg.sv
// ----------------------------------------------------------------------------
// Visibility zero-run decoder package
// Shared widths, constants and the decode-to-emit job record.
// ----------------------------------------------------------------------------
package vzr_pkg;

	localparam int unsigned CNT_W         = 14;
	localparam int unsigned CMP_W         = CNT_W + 1;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned BIT_SEL_W     = 3;
	localparam int unsigned SKIP_SHIFT    = 3;
	localparam int unsigned DEF_MAX_LEAVES = 8192;

	localparam logic [CNT_W-1:0] CNT_START = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] LEAF_COUNT_RESET = CNT_W'(1);

	typedef struct packed {
		logic [BYTE_W-1:0] mask;
		logic [CNT_W-1:0]  base;
		logic              row_done;
	} job_t;

endpackage

FILE: rtl/vzr_decode.sv
// ----------------------------------------------------------------------------
// Visibility zero-run decoder: byte decode
// Holds the leaf counter, the count-byte flag and the leaf count register,
// and turns each accepted word into a job for the emitter.
// ----------------------------------------------------------------------------
module vzr_decode #(
	parameter int unsigned MAX_LEAVES = vzr_pkg::DEF_MAX_LEAVES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [vzr_pkg::CNT_W-1:0]   cfg_wdata,
	input  logic                        accept,
	input  logic                        row_start,
	input  logic [vzr_pkg::BYTE_W-1:0]  vis_byte,
	output vzr_pkg::job_t               job
);

	localparam logic [vzr_pkg::CMP_W-1:0] MAX_LIM = vzr_pkg::CMP_W'(MAX_LEAVES);

	logic [vzr_pkg::CNT_W-1:0] leaf_count_q;
	logic [vzr_pkg::CNT_W-1:0] counter_q;
	logic                      expect_q;

	logic [vzr_pkg::CMP_W-1:0] lc_ext;
	logic [vzr_pkg::CMP_W-1:0] limit;
	logic [vzr_pkg::CNT_W-1:0] cnt0;
	logic                      exp0;
	logic [vzr_pkg::CMP_W-1:0] add_val;
	logic [vzr_pkg::CMP_W-1:0] sum;
	logic [vzr_pkg::CNT_W-1:0] sum_sat;
	logic [vzr_pkg::CNT_W-1:0] cnt_next;
	logic                      exp_next;
	logic [vzr_pkg::BYTE_W-1:0] mask;

	always_comb begin
		lc_ext = {1'b0, leaf_count_q};
		limit  = (lc_ext > MAX_LIM) ? MAX_LIM : lc_ext;
		cnt0   = row_start ? vzr_pkg::CNT_START : counter_q;
		exp0   = row_start ? 1'b0 : expect_q;
		if (exp0) begin
			add_val = vzr_pkg::CMP_W'(vis_byte) << vzr_pkg::SKIP_SHIFT;
		end else begin
			add_val = vzr_pkg::CMP_W'(vzr_pkg::BYTE_W);
		end
		sum     = {1'b0, cnt0} + add_val;
		sum_sat = sum[vzr_pkg::CMP_W-1] ? vzr_pkg::CNT_MAX : sum[vzr_pkg::CNT_W-1:0];
		cnt_next = cnt0;
		exp_next = 1'b0;
		mask     = '0;
		priority if (exp0) begin
			cnt_next = sum_sat;
		end else if ({1'b0, cnt0} >= limit) begin
			cnt_next = cnt0;
		end else if (vis_byte == '0) begin
			exp_next = 1'b1;
		end else begin
			cnt_next = sum_sat;
			mask     = vis_byte;
		end
		job.mask     = mask;
		job.base     = cnt0;
		job.row_done = ({1'b0, cnt_next} >= limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= vzr_pkg::LEAF_COUNT_RESET;
		end else if (cfg_we) begin
			leaf_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= vzr_pkg::CNT_START;
			expect_q  <= 1'b0;
		end else if (accept) begin
			counter_q <= cnt_next;
			expect_q  <= exp_next;
		end
	end

endmodule

FILE: rtl/vzr_emit.sv
// ----------------------------------------------------------------------------
// Visibility zero-run decoder: result emitter
// Registers one job and walks its set bits, one result word per cycle while the
// output is not held by out_ready, into the output register.
// ----------------------------------------------------------------------------
module vzr_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  vzr_pkg::job_t              job_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_leaf_valid,
	output logic [vzr_pkg::CNT_W-1:0]  out_leaf_index,
	output logic                       out_last,
	output logic                       out_row_done
);

	vzr_pkg::job_t job_q;
	logic          job_valid_q;

	logic                          out_free;
	logic                          load;
	logic                          consumed;
	logic [vzr_pkg::BIT_SEL_W-1:0] pos;
	logic [vzr_pkg::BYTE_W-1:0]    rest;
	logic [vzr_pkg::CMP_W-1:0]     idx_sum;
	logic [vzr_pkg::CNT_W-1:0]     idx_sat;
	logic                          sel_valid;
	logic                          sel_last;

	always_comb begin
		pos = '0;
		for (int i = vzr_pkg::BYTE_W - 1; i >= 0; i--) begin
			if (job_q.mask[i]) begin
				pos = vzr_pkg::BIT_SEL_W'(i);
			end
		end
		rest      = job_q.mask & (job_q.mask - vzr_pkg::BYTE_W'(1));
		sel_valid = (job_q.mask != '0);
		sel_last  = (rest == '0);
		idx_sum   = {1'b0, job_q.base} + vzr_pkg::CMP_W'(pos);
		idx_sat   = idx_sum[vzr_pkg::CMP_W-1] ? vzr_pkg::CNT_MAX
		                                      : idx_sum[vzr_pkg::CNT_W-1:0];
		out_free  = !out_valid || out_ready;
		load      = out_free && job_valid_q;
		consumed  = load && sel_last;
		in_ready  = !job_valid_q || consumed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			job_valid_q <= 1'b1;
		end else if (consumed) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_q <= job_in;
		end else if (load) begin
			job_q.mask <= rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= job_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_leaf_valid <= sel_valid;
			out_leaf_index <= sel_valid ? idx_sat : '0;
			out_last       <= sel_last;
			out_row_done   <= job_q.row_done;
		end
	end

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid_q |-> in_ready)
		else $error("emitter refuses a word while holding no job");

	a_more_after: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !sel_last) |=> job_valid_q)
		else $error("job dropped before its last result");

	a_blank_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_leaf_valid) |-> (out_last && out_leaf_index == '0))
		else $error("result without a leaf is not a lone last word");

	a_index_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_leaf_valid) |-> (out_leaf_index != '0))
		else $error("visible leaf index zero");

endmodule

FILE: rtl/visibility_zero_run_decoder.sv
// ----------------------------------------------------------------------------
// Visibility zero-run row decoder
// An accepted word's job is registered in the emitter; its first result then goes to the output register.
// One result word per cycle while m_axis_tready does not hold the output; a byte yields one word per leaf, else one.
// The emitter walking the set bits of a byte sets that rate; new bytes follow back to back.
// Reset is asynchronous: counter 1, no count pending, leaf count 1, both stages empty.
// ----------------------------------------------------------------------------
module visibility_zero_run_decoder #(
	parameter int unsigned MAX_LEAVES = vzr_pkg::DEF_MAX_LEAVES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [vzr_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,  // [7:0] vis_byte
	input  logic                       s_axis_tuser,  // [0] row_start
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [15:0]                m_axis_tdata,  // [13:0] leaf_index, [15:14] zero
	output logic [1:0]                 m_axis_tuser,  // [0] leaf_valid, [1] row_done
	output logic                       m_axis_tlast
);

	vzr_pkg::job_t             job;
	logic                      accept;
	logic                      leaf_valid;
	logic [vzr_pkg::CNT_W-1:0] leaf_index;
	logic                      row_done;

	assign accept = s_axis_tvalid && s_axis_tready;

	vzr_decode #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.row_start (s_axis_tuser),
		.vis_byte  (s_axis_tdata),
		.job       (job)
	);

	vzr_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.job_in         (job),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_leaf_valid (leaf_valid),
		.out_leaf_index (leaf_index),
		.out_last       (m_axis_tlast),
		.out_row_done   (row_done)
	);

	assign m_axis_tdata = {2'b00, leaf_index};
	assign m_axis_tuser = {row_done, leaf_valid};

endmodule

FILE: tb/visibility_zero_run_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visibility zero-run decoder checker
// Watches the configuration port and both stream channels, predicts the leaf
// words of every accepted byte and compares each output word, field by field,
// with the oldest prediction. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module visibility_zero_run_decoder_checker #(
	parameter int unsigned MAX_LEAVES = vzr_pkg::DEF_MAX_LEAVES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [vzr_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // [7:0] vis_byte
	input  logic                      s_axis_tuser,  // [0] row_start
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [15:0]               m_axis_tdata,  // [13:0] leaf_index, [15:14] zero
	input  logic [1:0]                m_axis_tuser,  // [0] leaf_valid, [1] row_done
	input  logic                      m_axis_tlast,
	output int                        pending,
	output int                        fail_count
);

	typedef struct packed {
		logic                      leaf_valid;
		logic [vzr_pkg::CNT_W-1:0] leaf_index;
		logic                      last;
		logic                      row_done;
	} leaf_word_t;

	leaf_word_t                leaf_words_q[$];
	logic [vzr_pkg::CNT_W-1:0] leaf_count_reg;
	logic [vzr_pkg::CNT_W-1:0] leaf_ctr;
	logic                      count_pending;

	initial begin
		pending = 0;
		fail_count = 0;
		leaf_count_reg = vzr_pkg::LEAF_COUNT_RESET;
		leaf_ctr = vzr_pkg::CNT_START;
		count_pending = 1'b0;
	end

	function automatic logic [vzr_pkg::CNT_W-1:0] ctr_add(logic [vzr_pkg::CNT_W-1:0] a,
		int unsigned inc);
		int unsigned sum;
		sum = int'(a) + inc;
		return (sum > int'(vzr_pkg::CNT_MAX)) ? vzr_pkg::CNT_MAX : vzr_pkg::CNT_W'(sum);
	endfunction

	function automatic int unsigned row_limit();
		return (leaf_count_reg > MAX_LEAVES) ? MAX_LEAVES : int'(leaf_count_reg);
	endfunction

	task automatic decode_vis_byte(input logic start, input logic [7:0] vis);
		leaf_word_t words[8];
		int         n;
		int         i;
		logic       done;
		n = 0;
		if (start) begin
			leaf_ctr = vzr_pkg::CNT_START;
			count_pending = 1'b0;
		end
		if (count_pending) begin
			leaf_ctr = ctr_add(leaf_ctr, int'(vis) << vzr_pkg::SKIP_SHIFT);
			count_pending = 1'b0;
		end else if (leaf_ctr >= row_limit()) begin
			// The row is over, so the byte yields no leaves.
		end else if (vis == 8'h00) begin
			count_pending = 1'b1;
		end else begin
			for (i = 0; i < 8; i++) begin
				if (vis[i]) begin
					words[n] = '0;
					words[n].leaf_valid = 1'b1;
					words[n].leaf_index = leaf_ctr;
					n++;
				end
				leaf_ctr = ctr_add(leaf_ctr, 1);
			end
		end
		if (n == 0) begin
			words[0] = '0;
			n = 1;
		end
		done = (leaf_ctr >= row_limit());
		for (i = 0; i < n; i++) begin
			words[i].row_done = done;
			words[i].last = (i == n - 1);
			leaf_words_q.push_back(words[i]);
		end
	endtask

	task automatic compare_field(input string name, input int unsigned expv,
		input int unsigned actv);
		if (expv != actv) begin
			$error("%s mismatch: expected %0d, got %0d", name, expv, actv);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		leaf_word_t exp_word;
		if (!arst_n) begin
			leaf_words_q.delete();
			leaf_count_reg = vzr_pkg::LEAF_COUNT_RESET;
			leaf_ctr = vzr_pkg::CNT_START;
			count_pending = 1'b0;
		end else begin
			if (cfg_we) begin
				leaf_count_reg = cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (leaf_words_q.size() == 0) begin
					$error("unexpected leaf word: index %0d, flags %b, last %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					fail_count++;
				end else begin
					exp_word = leaf_words_q.pop_front();
					compare_field("leaf_valid", int'(exp_word.leaf_valid),
						int'(m_axis_tuser[0]));
					compare_field("leaf_index", int'(exp_word.leaf_index),
						int'(m_axis_tdata[13:0]));
					compare_field("last", int'(exp_word.last), int'(m_axis_tlast));
					compare_field("row_done", int'(exp_word.row_done),
						int'(m_axis_tuser[1]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_vis_byte(s_axis_tuser, s_axis_tdata);
			end
		end
		pending = leaf_words_q.size();
	end

endmodule

FILE: tb/visibility_zero_run_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visibility zero-run decoder testbench
// Drives directed and random visibility rows under several leaf counts, with
// random gaps on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module visibility_zero_run_decoder_tb;

	localparam int unsigned MAX_LEAVES  = vzr_pkg::DEF_MAX_LEAVES;
	localparam int          STALL_LIMIT = 2000;
	localparam int          SETTLE      = 8;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [vzr_pkg::CNT_W-1:0] cfg_wdata;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [7:0]                s_axis_tdata;  // [7:0] vis_byte
	logic                      s_axis_tuser;  // [0] row_start
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [15:0]               m_axis_tdata;  // [13:0] leaf_index, [15:14] zero
	logic [1:0]                m_axis_tuser;  // [0] leaf_valid, [1] row_done
	logic                      m_axis_tlast;

	int pending;
	int fail_count;
	int bytes_sent;
	int stall_cycles;
	bit steady;

	int leaf_count_plan[8] = '{8, 40, 200, 1, 8192, 0, 16383, 100};
	int byte_plan[8]       = '{45, 55, 55, 12, 65, 12, 55, 46};

	visibility_zero_run_decoder #(
		.MAX_LEAVES(MAX_LEAVES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	visibility_zero_run_decoder_checker #(
		.MAX_LEAVES(MAX_LEAVES)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_word(input logic start, input logic [7:0] vis);
		@(negedge clk);
		while (!steady && ($urandom_range(0, 99) < 20)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= start;
		s_axis_tdata <= vis;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_leaf_count(input int value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= vzr_pkg::CNT_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A row opens with row_start and mixes literal bytes, zero/count pairs
	// and a little noise.
	task automatic send_row();
		int   n;
		int   k;
		int   kind;
		logic first;
		n = $urandom_range(1, 16);
		first = 1'b1;
		for (k = 0; k < n; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				send_word(first, 8'($urandom_range(1, 255)));
			end else if (kind < 85) begin
				send_word(first, 8'h00);
				if ($urandom_range(0, 4) == 0) begin
					send_word(1'b0, 8'($urandom_range(0, 255)));
				end else begin
					send_word(1'b0, 8'($urandom_range(0, 15)));
				end
			end else begin
				send_word(first || ($urandom_range(0, 9) == 0), 8'($urandom_range(0, 255)));
			end
			first = 1'b0;
		end
	endtask

	initial begin
		int p;
		int k;
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		bytes_sent = 0;
		stall_cycles = 0;
		steady = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// With the reset leaf count the row is over before the first byte.
		send_word(1'b1, 8'hFF);

		write_leaf_count(64);
		send_word(1'b1, 8'h01);
		send_word(1'b0, 8'hFF);
		send_word(1'b0, 8'h80);
		send_word(1'b0, 8'h00);
		send_word(1'b0, 8'h00);
		send_word(1'b0, 8'h00);
		send_word(1'b0, 8'h02);
		send_word(1'b0, 8'h55);
		send_word(1'b0, 8'h00);
		send_word(1'b0, 8'hFF);
		send_word(1'b0, 8'h12);
		send_word(1'b1, 8'h00);

		// The pending count byte is still taken after the row has ended.
		write_leaf_count(1);
		send_word(1'b0, 8'h03);
		send_word(1'b0, 8'h40);

		write_leaf_count(0);
		send_word(1'b1, 8'h7F);

		// Leaf counts above the maximum are clamped to it.
		write_leaf_count(16383);
		send_word(1'b1, 8'h00);
		for (k = 0; k < 4; k++) begin
			send_word(1'b0, 8'hFF);
			send_word(1'b0, 8'h00);
		end
		send_word(1'b0, 8'h04);
		send_word(1'b0, 8'hFF);

		leaf_count_plan[7] = $urandom_range(2, 300);
		for (p = 0; p < 8; p++) begin
			write_leaf_count(leaf_count_plan[p]);
			steady = (p == 4);
			target = bytes_sent + byte_plan[p];
			while (bytes_sent < target) begin
				send_row();
			end
		end
		steady = 1'b0;

		wait_drained();
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
